### design/double_tap_wake_detector_macros.svh
`ifndef DOUBLE_TAP_WAKE_DETECTOR_MACROS_SVH
`define DOUBLE_TAP_WAKE_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define DTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define DTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/dtw_pkg.sv
package dtw_pkg;

	typedef enum logic [2:0] {
		CMD_SLOT  = 3'd0,
		CMD_TRACK = 3'd1,
		CMD_X     = 3'd2,
		CMD_Y     = 3'd3,
		CMD_OTHER = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ENABLE  = 2'd0,
		REG_FEATHER = 2'd1,
		REG_WINDOW  = 2'd2
	} reg_idx_t;

	localparam logic [15:0] LIFT_ID         = 16'hFFFF;
	localparam logic        ENABLE_RESET    = 1'b1;
	localparam logic [11:0] FEATHER_RESET   = 12'd50;
	localparam logic [15:0] WINDOW_RESET    = 16'd700;

	typedef struct packed {
		logic        enable;
		logic [11:0] feather;
		logic [15:0] window_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] value;
		logic [31:0] now_ms;
		logic        screen_off;
	} item_t;

endpackage

### design/dtw_cfg_regs.sv
module dtw_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [15:0]      wr_data,
	output dtw_pkg::cfg_t    cfg
);
	import dtw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= ENABLE_RESET;
			cfg_q.feather   <= FEATHER_RESET;
			cfg_q.window_ms <= WINDOW_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ENABLE:  cfg_q.enable    <= wr_data[0];
				REG_FEATHER: cfg_q.feather   <= wr_data[11:0];
				REG_WINDOW:  cfg_q.window_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/dtw_tap_core.sv
module dtw_tap_core #(
	parameter int CW = 16,
	parameter int TW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  dtw_pkg::item_t item,
	input  dtw_pkg::cfg_t  cfg,
	output logic          wake
);
	import dtw_pkg::*;

	logic          armed_q;
	logic [CW-1:0] first_x_q;
	logic [CW-1:0] first_y_q;
	logic [TW-1:0] first_time_q;
	logic [CW-1:0] latched_x_q;
	logic [CW-1:0] latched_y_q;

	logic          armed_n;
	logic [CW-1:0] first_x_n;
	logic [CW-1:0] first_y_n;
	logic [TW-1:0] first_time_n;
	logic [CW-1:0] latched_x_n;
	logic [CW-1:0] latched_y_n;

	logic [31:0]   val32;
	logic [CW-1:0] coord;
	logic [63:0]   now64;
	logic [63:0]   win64;
	logic [TW-1:0] now_t;
	logic [TW-1:0] win_t;
	logic [TW-1:0] dt;
	logic [CW-1:0] lx;
	logic [CW-1:0] ly;
	logic [CW:0]   dx;
	logic [CW:0]   dy;
	logic [CW:0]   adx;
	logic [CW:0]   ady;
	logic          proceed;
	logic          is_lift;
	logic          tap;
	logic          hit;

	assign val32   = 32'(signed'(item.value));
	assign coord   = val32[CW-1:0];
	assign now64   = 64'(item.now_ms);
	assign now_t   = now64[TW-1:0];
	assign win64   = 64'(cfg.window_ms);
	assign win_t   = win64[TW-1:0];
	assign proceed = cfg.enable & item.screen_off;
	assign is_lift = (item.command == CMD_TRACK) && (item.value == LIFT_ID);

	assign lx  = (item.command == CMD_X) ? coord : latched_x_q;
	assign ly  = (item.command == CMD_Y) ? coord : latched_y_q;
	assign tap = (lx != '0) && (ly != '0);

	assign dx  = {lx[CW-1], lx} - {first_x_q[CW-1], first_x_q};
	assign dy  = {ly[CW-1], ly} - {first_y_q[CW-1], first_y_q};
	assign adx = dx[CW] ? (~dx + 1'b1) : dx;
	assign ady = dy[CW] ? (~dy + 1'b1) : dy;
	assign dt  = now_t - first_time_q;

	assign hit = armed_q
		&& (64'(adx) < 64'(cfg.feather))
		&& (64'(ady) < 64'(cfg.feather))
		&& (dt < win_t);

	always_comb begin
		armed_n      = armed_q;
		first_x_n    = first_x_q;
		first_y_n    = first_y_q;
		first_time_n = first_time_q;
		latched_x_n  = latched_x_q;
		latched_y_n  = latched_y_q;
		wake         = 1'b0;
		priority if (!proceed) begin
		end else if (item.command == CMD_SLOT) begin
			armed_n      = 1'b0;
			first_x_n    = '0;
			first_y_n    = '0;
			first_time_n = '0;
			latched_x_n  = '0;
			latched_y_n  = '0;
		end else if (is_lift) begin
			armed_n     = 1'b1;
			latched_x_n = '0;
			latched_y_n = '0;
		end else if (tap) begin
			latched_x_n = '0;
			latched_y_n = '0;
			armed_n     = 1'b0;
			if (hit) begin
				wake         = 1'b1;
				first_x_n    = '0;
				first_y_n    = '0;
				first_time_n = '0;
			end else begin
				first_x_n    = lx;
				first_y_n    = ly;
				first_time_n = now_t;
			end
		end else begin
			latched_x_n = lx;
			latched_y_n = ly;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b1;
			first_x_q    <= '0;
			first_y_q    <= '0;
			first_time_q <= '0;
			latched_x_q  <= '0;
			latched_y_q  <= '0;
		end else if (step) begin
			armed_q      <= armed_n;
			first_x_q    <= first_x_n;
			first_y_q    <= first_y_n;
			first_time_q <= first_time_n;
			latched_x_q  <= latched_x_n;
			latched_y_q  <= latched_y_n;
		end
	end

endmodule

### design/double_tap_wake_detector.sv
// Double-tap wake detector. Touch events go into an input register; the tap
// logic evaluates the registered item against the stored first tap and
// writes the wake flag into the result register, so one item is taken every
// cycle unless in_stall is high, and each result passes from the input
// register through the result register. in_stall rises only while the result
// register is full and out_stall holds it. Configuration writes are always
// ready and take effect on the next item; write them only while the block is idle.
module double_tap_wake_detector #(
	parameter int COORD_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] value,
	input  logic [31:0] now_ms,
	input  logic        screen_off,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        wake,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dtw_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	logic  wake_q;
	logic  advance;
	logic  step;
	logic  wake_n;

	assign cfg_ready = 1'b1;
	assign advance   = ~out_valid_q | ~out_stall;
	assign step      = valid_s1 & advance;
	assign in_stall  = valid_s1 & ~advance;

	dtw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.command    <= command;
			item_s1.value      <= value;
			item_s1.now_ms     <= now_ms;
			item_s1.screen_off <= screen_off;
		end
	end

	dtw_tap_core #(
		.CW (COORD_WIDTH),
		.TW (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.wake   (wake_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			wake_q <= wake_n;
		end
	end

	assign out_valid = out_valid_q;
	assign wake      = wake_q;

endmodule

### design/dtw_checker.sv
`include "double_tap_wake_detector_macros.svh"

module dtw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic wake
);

	`DTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(wake), "stalled result changed")
	`DTW_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without full output")
	`DTW_ASSERT_NOW(a_no_phantom, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without item")
	`DTW_ASSERT_NEXT(a_wake_gap, out_valid && !out_stall && wake, !(out_valid && wake), "wake on adjacent items")

endmodule

bind double_tap_wake_detector dtw_checker u_dtw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.wake      (wake)
);

### sim/tb_double_tap_wake_detector.sv
module tb_double_tap_wake_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import dtw_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = 3'd0;
	logic [15:0] value = 16'd0;
	logic [31:0] now_ms = 32'd0;
	logic        screen_off = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        wake;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;

	double_tap_wake_detector i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.value      (value),
		.now_ms     (now_ms),
		.screen_off (screen_off),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.wake       (wake),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// predictor copy of the registers and tap state
	logic        en_r = ENABLE_RESET;
	logic [11:0] feather_r = FEATHER_RESET;
	logic [15:0] window_r = WINDOW_RESET;
	logic        is_armed = 1'b1;
	logic [15:0] anchor_x = 16'd0;
	logic [15:0] anchor_y = 16'd0;
	logic [31:0] anchor_ms = 32'd0;
	logic [15:0] pend_x = 16'd0;
	logic [15:0] pend_y = 16'd0;

	item_t       event_q[$];
	logic        wake_expect[$];
	item_t       next_ev;
	logic        exp_wake;
	int          in_gap = 0;
	int          out_gap = 0;
	int          idle_cycles = 0;
	int          mismatches = 0;
	int unsigned events_made = 0;
	logic [31:0] clock_ms = 32'd0;
	bit          calm = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [16:0] axis_gap(logic [15:0] a, logic [15:0] b);
		logic signed [16:0] d;
		d = $signed({a[15], a}) - $signed({b[15], b});
		return d < 0 ? 17'(-d) : 17'(d);
	endfunction

	function automatic void drop_taps();
		is_armed = 1'b0;
		anchor_x = 16'd0;
		anchor_y = 16'd0;
		anchor_ms = 32'd0;
		pend_x = 16'd0;
		pend_y = 16'd0;
	endfunction

	function automatic logic predict_wake(item_t ev);
		logic [15:0] tx;
		logic [15:0] ty;
		logic hit;
		if (!en_r || !ev.screen_off)
			return 1'b0;
		if (ev.command == CMD_SLOT) begin
			drop_taps();
			return 1'b0;
		end
		if (ev.command == CMD_TRACK && ev.value == LIFT_ID) begin
			is_armed = 1'b1;
			pend_x = 16'd0;
			pend_y = 16'd0;
			return 1'b0;
		end
		if (ev.command == CMD_X)
			pend_x = ev.value;
		if (ev.command == CMD_Y)
			pend_y = ev.value;
		if (pend_x == 16'd0 || pend_y == 16'd0)
			return 1'b0;
		tx = pend_x;
		ty = pend_y;
		pend_x = 16'd0;
		pend_y = 16'd0;
		hit = is_armed && axis_gap(tx, anchor_x) < feather_r &&
			axis_gap(ty, anchor_y) < feather_r && (ev.now_ms - anchor_ms) < window_r;
		if (is_armed)
			drop_taps();
		if (!hit) begin
			anchor_ms = ev.now_ms;
			anchor_x = tx;
			anchor_y = ty;
		end
		return hit;
	endfunction

	function automatic void push_event(logic [2:0] cmd, logic [15:0] val, logic [31:0] t,
			logic soff);
		event_q.push_back(item_t'{cmd, val, t, soff});
		events_made++;
	endfunction

	function automatic void push_tap(logic [15:0] x, logic [15:0] y, logic [31:0] t,
			logic soff);
		push_event(CMD_X, x, t, soff);
		push_event(CMD_Y, y, t, soff);
	endfunction

	function automatic void tick();
		case ($urandom_range(0, 39))
			0: clock_ms = $urandom();
			1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
			default: clock_ms += $urandom_range(0, window_r + window_r / 2 + 3);
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ENABLE: en_r = data[0];
			REG_FEATHER: feather_r = data[11:0];
			REG_WINDOW: window_r = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic en, logic [11:0] fth, logic [15:0] win);
		write_reg(REG_ENABLE, {15'd0, en});
		write_reg(REG_FEATHER, {4'd0, fth});
		write_reg(REG_WINDOW, win);
	endtask

	task automatic drain();
		while (event_q.size() != 0 || in_valid || wake_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly lift/tap/lift/tap gestures around a random point, plus slots and noise
	task automatic queue_touch_traffic(int unsigned n);
		int unsigned target;
		int sel;
		int spread;
		int dx;
		int dy;
		logic [15:0] bx;
		logic [15:0] by;
		logic soff;
		target = events_made + n;
		while (events_made < target) begin
			sel = $urandom_range(0, 99);
			soff = ($urandom_range(0, 19) != 0);
			if (sel < 60) begin
				bx = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 200)) : 16'($urandom());
				by = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 200)) : 16'($urandom());
				if ($urandom_range(0, 4) != 0)
					push_event(CMD_TRACK, LIFT_ID, clock_ms, soff);
				if ($urandom_range(0, 1) == 0)
					push_tap(bx, by, clock_ms, soff);
				else begin
					push_event(CMD_Y, by, clock_ms, soff);
					push_event(CMD_X, bx, clock_ms, soff);
				end
				push_event(CMD_TRACK, LIFT_ID, clock_ms, soff);
				tick();
				spread = int'(feather_r) + 2;
				dx = $urandom_range(0, 2 * spread) - spread;
				dy = $urandom_range(0, 2 * spread) - spread;
				push_tap(bx + 16'(dx), by + 16'(dy), clock_ms, soff);
				tick();
			end else if (sel < 68) begin
				push_event(CMD_SLOT, 16'($urandom()), clock_ms, soff);
			end else if (sel < 85) begin
				case ($urandom_range(0, 2))
					0: push_event(CMD_X, 16'($urandom()), clock_ms, soff);
					1: push_event(CMD_Y, 16'($urandom()), clock_ms, soff);
					default: push_event(CMD_TRACK, 16'($urandom()), clock_ms, soff);
				endcase
				tick();
			end else begin
				push_event(3'($urandom_range(0, 7)), 16'($urandom()), $urandom(),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				wake_expect.push_back(predict_wake(item_t'({command, value, now_ms, screen_off})));
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					in_gap = $urandom_range(1, 9) - 1;
					in_valid <= 1'b0;
				end else if (event_q.size() != 0) begin
					next_ev = event_q.pop_front();
					in_valid <= 1'b1;
					command <= next_ev.command;
					value <= next_ev.value;
					now_ms <= next_ev.now_ms;
					screen_off <= next_ev.screen_off;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (wake_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected item, wake=%b", $realtime, wake);
				end else begin
					exp_wake = wake_expect.pop_front();
					if (wake !== exp_wake) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: wake mismatch, expected %b actual %b", $realtime,
								exp_wake, wake);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				out_gap = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL double_tap_wake_detector");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: tap near origin, zero coordinate, non-lift ids, unused codes,
		// screen on, coordinate extremes, timer wrap, feather boundary
		push_event(CMD_X, 16'd10, 32'd100, 1'b1);
		push_event(CMD_Y, 16'd10, 32'd100, 1'b1);
		push_event(CMD_OTHER, 16'd5, 32'd150, 1'b1);
		push_event(CMD_X, 16'd0, 32'd200, 1'b1);
		push_event(CMD_Y, 16'd300, 32'd200, 1'b1);
		push_event(CMD_X, 16'd300, 32'd200, 1'b1);
		push_event(CMD_TRACK, 16'd5, 32'd300, 1'b1);
		push_event(CMD_TRACK, LIFT_ID, 32'd400, 1'b1);
		push_tap(16'd320, 16'd330, 32'd800, 1'b1);
		push_event(CMD_TRACK, LIFT_ID, 32'd900, 1'b1);
		push_tap(16'h8000, 16'h7FFF, 32'hFFFF_FF00, 1'b1);
		push_event(CMD_TRACK, LIFT_ID, 32'hFFFF_FF80, 1'b1);
		push_tap(16'h8008, 16'h7FF8, 32'h0000_0100, 1'b1);
		push_event(CMD_SLOT, 16'd0, 32'd1000, 1'b1);
		push_event(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		push_event(CMD_X, 16'd5, 32'd1000, 1'b0);
		push_event(CMD_TRACK, LIFT_ID, 32'd5000, 1'b1);
		push_tap(16'd1000, 16'd1000, 32'd5000, 1'b1);
		push_event(CMD_TRACK, LIFT_ID, 32'd5600, 1'b1);
		push_tap(16'd1049, 16'd1000, 32'd5699, 1'b1);
		push_tap(16'd2000, 16'd2000, 32'd9000, 1'b1);
		push_event(CMD_TRACK, LIFT_ID, 32'd9050, 1'b1);
		push_tap(16'd2050, 16'd2000, 32'd9100, 1'b1);
		drain();

		set_config(1'b1, 12'd4095, 16'hFFFF);
		queue_touch_traffic(220);
		drain();
		set_config(1'b1, 12'd0, 16'd0);
		queue_touch_traffic(180);
		drain();
		set_config(1'b0, FEATHER_RESET, WINDOW_RESET);
		queue_touch_traffic(120);
		drain();
		set_config(1'b1, 12'd1, 16'd1);
		queue_touch_traffic(180);
		drain();
		repeat (4) begin
			set_config(1'b1, 12'($urandom_range(2, 300)), 16'($urandom_range(50, 3000)));
			queue_touch_traffic(200);
			drain();
		end
		calm = 1'b1;
		set_config(1'b1, FEATHER_RESET, WINDOW_RESET);
		queue_touch_traffic(200);
		drain();

		if (mismatches == 0 && wake_expect.size() == 0)
			$display("PASS double_tap_wake_detector");
		else
			$display("FAIL double_tap_wake_detector");
		$finish;
	end

endmodule

### double_tap_wake_detector.f
+incdir+design
design/dtw_pkg.sv
design/dtw_cfg_regs.sv
design/dtw_tap_core.sv
design/double_tap_wake_detector.sv
design/dtw_checker.sv
sim/tb_double_tap_wake_detector.sv
